/* hw/rtl/hbcf_pkg.sv */
// Shared types and constants of the hydrogen bond class filter.
// No dependencies; imported by hbcf_dist_unit and hydrogen_bond_class_filter.
package hbcf_pkg;

	localparam int IDX_IN_W  = 12;
	localparam int POS_W     = 20;
	localparam int DIFF_W    = POS_W + 1;
	localparam int SQ_W      = 2 * DIFF_W;
	localparam int ACC_W     = SQ_W + 1;
	localparam int DIST_W    = 16;
	localparam int CLASS_W   = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;
	localparam int IN_DATA_W = 112;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_CNT_W = 16;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_BOND  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	localparam logic [CLASS_W-1:0] CLASS_HELIX = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_SHEET = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOW_HLX  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOW_SHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOW_OTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_CA     = 3'd4;

	localparam logic [DIST_W-1:0] MAX_DIST_RST = 16'd2560;

	typedef struct packed {
		logic start;
	} dist_ctl_t;

	typedef struct packed {
		logic done;
		logic in_range;
	} dist_sts_t;

endpackage

/* hw/rtl/hbcf_dist_unit.sv */
// Squared-distance check with one shared 21x21 squarer.
// Depends on hbcf_pkg.
module hbcf_dist_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  hbcf_pkg::dist_ctl_t                    ctl,
	input  logic signed [hbcf_pkg::DIFF_W-1:0]     dx,
	input  logic signed [hbcf_pkg::DIFF_W-1:0]     dy,
	input  logic signed [hbcf_pkg::DIFF_W-1:0]     dz,
	input  logic [hbcf_pkg::DIST_W-1:0]            max_dist,
	output hbcf_pkg::dist_sts_t                    sts
);
	import hbcf_pkg::*;

	logic [2:0]               step_q;
	logic                     busy_q;
	logic signed [DIFF_W-1:0] op;
	logic signed [SQ_W-1:0]   sq;
	logic [SQ_W-1:0]          prod_q;
	logic [ACC_W-1:0]         acc_q;

	always_comb begin
		case (step_q)
			3'd0:    op = dx;
			3'd1:    op = dy;
			3'd2:    op = dz;
			default: op = $signed({{(DIFF_W-DIST_W){1'b0}}, max_dist});
		endcase
		sq = op * op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
		end else if (ctl.start) begin
			step_q <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (step_q == 3'd4) begin
				busy_q <= 1'b0;
			end
			step_q <= step_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q <= '0;
		end else if (busy_q) begin
			prod_q <= sq;
			// products of dx, dy, dz are registered in prod_q and added in the following step
			if (step_q >= 3'd1 && step_q <= 3'd3) begin
				acc_q <= acc_q + ACC_W'(prod_q);
			end
		end
	end

	// at step 4 prod_q holds max_dist squared and acc_q the full sum
	always_comb begin
		sts.done     = busy_q && (step_q == 3'd4);
		sts.in_range = acc_q <= ACC_W'(prod_q);
	end

endmodule

/* hw/rtl/hydrogen_bond_class_filter.sv */
// Hydrogen bond class filter: atom tables, helix-run walk, distance check, histogram.
// Depends on hbcf_pkg and hbcf_dist_unit.
//
// One request at a time; s_tready is high only while the sequencer is idle, and a finished
// result may wait in the output register while the next request is taken. A bond reads
// the class table once per atom from the lower to the higher index when both ends are helix,
// runs the distance check on the shared squarer, and when it is kept does a read-modify-write
// of two histogram entries. Every request waits in its done state while the previous result
// is still unaccepted. After reset the histogram is swept to zero before the first request
// is taken.
module hydrogen_bond_class_filter #(
	parameter int ATOM_SLOTS = 4096,
	parameter int COUNT_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// atom_index, structure_class, calpha_index, pos_x, pos_y, pos_z, donor_atom,
	// acceptor_atom, zero pad
	input  logic [hbcf_pkg::IN_DATA_W-1:0]      s_tdata,
	// command
	input  logic [1:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// out_donor, out_acceptor, bond_count
	output logic [hbcf_pkg::OUT_DATA_W-1:0]     m_tdata,
	// kept
	output logic                                m_tuser,
	input  logic                                cfg_we,
	input  logic [hbcf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [hbcf_pkg::CFG_DAT_W-1:0]      cfg_data
);
	import hbcf_pkg::*;

	localparam int IDX_W = (ATOM_SLOTS > 1) ? $clog2(ATOM_SLOTS) : 1;
	localparam logic [COUNT_BITS-1:0] CNT_TOP = {COUNT_BITS{1'b1}};

	typedef enum logic [15:0] {
		ST_CLR    = 16'h0001,
		ST_IDLE   = 16'h0002,
		ST_RDD    = 16'h0004,
		ST_RDA    = 16'h0008,
		ST_CAPA   = 16'h0010,
		ST_WALK   = 16'h0020,
		ST_WLAST  = 16'h0040,
		ST_DSTART = 16'h0080,
		ST_DIST   = 16'h0100,
		ST_CRD1   = 16'h0200,
		ST_CWR1   = 16'h0400,
		ST_CRD2   = 16'h0800,
		ST_CWR2   = 16'h1000,
		ST_CRD    = 16'h2000,
		ST_CCAP   = 16'h4000,
		ST_DONE   = 16'h8000
	} state_t;

	function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_IN_W-1:0] v);
		logic [IDX_IN_W-1:0] r;
		r = v;
		for (int k = IDX_IN_W - 1; k >= 0; k--) begin
			if (64'(r) >= (64'(ATOM_SLOTS) << k)) begin
				r = r - IDX_IN_W'(64'(ATOM_SLOTS) << k);
			end
		end
		return IDX_W'(r);
	endfunction

	// input fields
	logic [IDX_IN_W-1:0] in_atom, in_cal, in_donor, in_acc;
	logic [CLASS_W-1:0]  in_cls;
	logic [3*POS_W-1:0]  in_pos;
	assign in_atom  = s_tdata[11:0];
	assign in_cls   = s_tdata[13:12];
	assign in_cal   = s_tdata[25:14];
	assign in_pos   = s_tdata[85:26];
	assign in_donor = s_tdata[97:86];
	assign in_acc   = s_tdata[109:98];

	// configuration
	logic [DIST_W-1:0] max_dist_q;
	logic allow_hlx_q, allow_sht_q, allow_oth_q, map_ca_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dist_q  <= MAX_DIST_RST;
			allow_hlx_q <= 1'b1;
			allow_sht_q <= 1'b1;
			allow_oth_q <= 1'b1;
			map_ca_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_DIST:  max_dist_q  <= cfg_data;
				REG_ALLOW_HLX: allow_hlx_q <= cfg_data[0];
				REG_ALLOW_SHT: allow_sht_q <= cfg_data[0];
				REG_ALLOW_OTH: allow_oth_q <= cfg_data[0];
				REG_MAP_CA:    map_ca_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	state_t state_q;
	logic   accept;
	cmd_t   cmd;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign cmd      = cmd_t'(s_tuser);

	// atom tables
	logic [CLASS_W-1:0]  cls_mem [ATOM_SLOTS];
	logic [IDX_IN_W-1:0] cal_mem [ATOM_SLOTS];
	logic [3*POS_W-1:0]  pos_mem [ATOM_SLOTS];
	logic [IDX_W-1:0]    mem_addr;
	logic [CLASS_W-1:0]  cls_rd_q;
	logic [IDX_IN_W-1:0] cal_rd_q;
	logic [3*POS_W-1:0]  pos_rd_q;
	logic                load_we;

	assign load_we = accept && (cmd == CMD_LOAD);

	always_ff @(posedge clk) begin
		if (load_we) begin
			cls_mem[slot_of(in_atom)] <= in_cls;
			cal_mem[slot_of(in_atom)] <= in_cal;
			pos_mem[slot_of(in_atom)] <= in_pos;
		end
		cls_rd_q <= cls_mem[mem_addr];
		cal_rd_q <= cal_mem[mem_addr];
		pos_rd_q <= pos_mem[mem_addr];
	end

	// histogram
	logic [COUNT_BITS-1:0] cnt_mem [ATOM_SLOTS];
	logic [IDX_W-1:0]      cnt_addr;
	logic                  cnt_we;
	logic [COUNT_BITS-1:0] cnt_wdata;
	logic [COUNT_BITS-1:0] cnt_rd_q;

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_addr] <= cnt_wdata;
		end
		cnt_rd_q <= cnt_mem[cnt_addr];
	end

	// working registers
	logic [IDX_W-1:0]    d_q, a_q, idx_q, walk_q, clr_q, hi_q;
	logic [IDX_IN_W-1:0] cal_d_q, od_q, oa_q;
	logic [3*POS_W-1:0]  pos_d_q, pos_a_q;
	logic                keep_cls_q, chk_v_q, run_ok_q, clr_cmd_q;
	logic                res_kept_q;
	logic [IDX_IN_W-1:0] res_d_q, res_a_q;
	logic [OUT_CNT_W-1:0] res_cnt_q;
	logic                out_v_q, out_kept_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic [CLASS_W-1:0] cls_d_q;
	logic both_hlx, both_sht;
	assign both_hlx = (cls_d_q == CLASS_HELIX) && (cls_rd_q == CLASS_HELIX);
	assign both_sht = (cls_d_q == CLASS_SHEET) && (cls_rd_q == CLASS_SHEET);

	logic [COUNT_BITS-1:0] cnt_inc;
	assign cnt_inc = (cnt_rd_q < CNT_TOP) ? cnt_rd_q + COUNT_BITS'(1) : cnt_rd_q;

	always_comb begin
		mem_addr  = d_q;
		cnt_addr  = idx_q;
		cnt_we    = 1'b0;
		cnt_wdata = cnt_inc;
		case (state_q)
			ST_RDA:  mem_addr = a_q;
			ST_WALK: mem_addr = walk_q;
			ST_CLR: begin
				cnt_addr  = clr_q;
				cnt_we    = 1'b1;
				cnt_wdata = '0;
			end
			ST_CRD1: cnt_addr = slot_of(od_q);
			ST_CWR1: begin
				cnt_addr = slot_of(od_q);
				cnt_we   = 1'b1;
			end
			ST_CRD2: cnt_addr = slot_of(oa_q);
			ST_CWR2: begin
				cnt_addr = slot_of(oa_q);
				cnt_we   = 1'b1;
			end
			default: ;
		endcase
	end

	// distance unit
	dist_ctl_t dctl;
	dist_sts_t dsts;
	logic signed [DIFF_W-1:0] dx, dy, dz;

	assign dctl.start = (state_q == ST_DSTART);
	assign dx = $signed({pos_a_q[POS_W-1], pos_a_q[POS_W-1:0]})
		- $signed({pos_d_q[POS_W-1], pos_d_q[POS_W-1:0]});
	assign dy = $signed({pos_a_q[2*POS_W-1], pos_a_q[2*POS_W-1:POS_W]})
		- $signed({pos_d_q[2*POS_W-1], pos_d_q[2*POS_W-1:POS_W]});
	assign dz = $signed({pos_a_q[3*POS_W-1], pos_a_q[3*POS_W-1:2*POS_W]})
		- $signed({pos_d_q[3*POS_W-1], pos_d_q[3*POS_W-1:2*POS_W]});

	hbcf_dist_unit u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (dctl),
		.dx       (dx),
		.dy       (dy),
		.dz       (dz),
		.max_dist (max_dist_q),
		.sts      (dsts)
	);

	logic keep_now;
	assign keep_now = keep_cls_q && (d_q != a_q) && dsts.in_range;

	// result register takes the finished request once the previous one has left
	logic out_load;
	assign out_load = (state_q == ST_DONE) && (!out_v_q || m_tready);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_q     <= '0;
			clr_cmd_q <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(ATOM_SLOTS - 1)) begin
						clr_q   <= '0;
						state_q <= clr_cmd_q ? ST_DONE : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (cmd)
							CMD_LOAD:  state_q <= ST_DONE;
							CMD_BOND:  state_q <= ST_RDD;
							CMD_READ:  state_q <= ST_CRD;
							CMD_CLEAR: begin
								clr_cmd_q <= 1'b1;
								state_q   <= ST_CLR;
							end
							default:   state_q <= ST_DONE;
						endcase
					end
				end
				ST_RDD:    state_q <= ST_RDA;
				ST_RDA:    state_q <= ST_CAPA;
				ST_CAPA:   state_q <= both_hlx ? ST_WALK : ST_DSTART;
				ST_WALK:   state_q <= (walk_q == hi_q) ? ST_WLAST : ST_WALK;
				ST_WLAST:  state_q <= ST_DSTART;
				ST_DSTART: state_q <= ST_DIST;
				ST_DIST: begin
					if (dsts.done) begin
						state_q <= keep_now ? ST_CRD1 : ST_DONE;
					end
				end
				ST_CRD1:   state_q <= ST_CWR1;
				ST_CWR1:   state_q <= ST_CRD2;
				ST_CRD2:   state_q <= ST_CWR2;
				ST_CWR2:   state_q <= ST_DONE;
				ST_CRD:    state_q <= ST_CCAP;
				ST_CCAP:   state_q <= ST_DONE;
				ST_DONE: begin
					if (out_load) begin
						clr_cmd_q <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				res_kept_q <= 1'b0;
				res_d_q    <= '0;
				res_a_q    <= '0;
				res_cnt_q  <= '0;
				d_q        <= slot_of(in_donor);
				a_q        <= slot_of(in_acc);
				idx_q      <= slot_of(in_atom);
			end
			ST_RDA: begin
				cls_d_q <= cls_rd_q;
				cal_d_q <= cal_rd_q;
				pos_d_q <= pos_rd_q;
			end
			ST_CAPA: begin
				pos_a_q <= pos_rd_q;
				od_q    <= map_ca_q ? cal_d_q : IDX_IN_W'(d_q);
				oa_q    <= map_ca_q ? cal_rd_q : IDX_IN_W'(a_q);
				keep_cls_q <= both_sht ? allow_sht_q : allow_oth_q;
				walk_q  <= (d_q < a_q) ? d_q : a_q;
				hi_q    <= (d_q < a_q) ? a_q : d_q;
				chk_v_q  <= 1'b0;
				run_ok_q <= 1'b1;
			end
			ST_WALK: begin
				chk_v_q <= 1'b1;
				if (chk_v_q && cls_rd_q != CLASS_HELIX) begin
					run_ok_q <= 1'b0;
				end
				if (walk_q != hi_q) begin
					walk_q <= walk_q + IDX_W'(1);
				end
			end
			ST_WLAST: begin
				keep_cls_q <= (run_ok_q && cls_rd_q == CLASS_HELIX) ? allow_hlx_q : allow_oth_q;
			end
			ST_DIST: begin
				if (dsts.done && keep_now) begin
					res_kept_q <= 1'b1;
					res_d_q    <= od_q;
					res_a_q    <= oa_q;
				end
			end
			ST_CCAP: begin
				if (COUNT_BITS > OUT_CNT_W && cnt_rd_q > COUNT_BITS'({OUT_CNT_W{1'b1}})) begin
					res_cnt_q <= {OUT_CNT_W{1'b1}};
				end else begin
					res_cnt_q <= OUT_CNT_W'(cnt_rd_q);
				end
			end
			ST_DONE: begin
				if (out_load) begin
					out_kept_q <= res_kept_q;
					out_data_q <= {res_cnt_q, res_a_q, res_d_q};
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kept_q;

endmodule
